/* sv/bfa_pkg.sv */
// Shared constants and helper functions for the bitmap frame allocator.
package bfa_pkg;

    localparam int WORD_BITS = 64;

    localparam logic [2:0] MODE_BEGIN  = 3'd0;
    localparam logic [2:0] MODE_MAP    = 3'd1;
    localparam logic [2:0] MODE_FINISH = 3'd2;
    localparam logic [2:0] MODE_ALLOC  = 3'd3;
    localparam logic [2:0] MODE_FREE   = 3'd4;

    localparam logic [2:0] KIND_USABLE      = 3'd0;
    localparam logic [2:0] KIND_BOOT_RECL   = 3'd3;
    localparam logic [2:0] KIND_KERNEL      = 3'd4;
    localparam logic [2:0] KIND_FRAMEBUFFER = 3'd5;

    // Saturating add of a region length to a byte total.
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [47:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    // Bit position of a one-hot word.
    function automatic logic [5:0] onehot_index(input logic [63:0] oh);
        logic [5:0] idx;
        idx = '0;
        for (int k = 0; k < 6; k++)
        begin
            for (int i = 0; i < 64; i++)
            begin
                if (((i >> k) & 1) == 1)
                begin
                    idx[k] = idx[k] | oh[i];
                end
            end
        end
        return idx;
    endfunction

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage

/* sv/bfa_if.sv */
// Request and response channel interfaces of the bitmap frame allocator.
interface bfa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [47:0] region_base;
    logic [47:0] region_length;
    logic [2:0]  region_kind;
    logic [47:0] free_address;

    modport source(output valid, mode, region_base, region_length, region_kind, free_address,
                   input ready);
    modport sink(input valid, mode, region_base, region_length, region_kind, free_address,
                 output ready);
endinterface

interface bfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [47:0] result_address;
    logic        status;
    logic [16:0] free_count;
    logic [16:0] tracked_count;
    logic [63:0] total_bytes;
    logic [63:0] usable_bytes;
    logic [63:0] kernel_bytes;
    logic [63:0] framebuffer_bytes;
    logic [63:0] reclaimable_bytes;

    modport source(output valid, result_address, status, free_count, tracked_count,
                   total_bytes, usable_bytes, kernel_bytes, framebuffer_bytes,
                   reclaimable_bytes, input ready);
    modport sink(input valid, result_address, status, free_count, tracked_count,
                 total_bytes, usable_bytes, kernel_bytes, framebuffer_bytes,
                 reclaimable_bytes, output ready);
endinterface

/* sv/bfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/bitmap_frame_allocator.sv */
// Bitmap page frame allocator, top level.
// Tracks TRACKED_FRAMES frames of 2^FRAME_SHIFT bytes in two bitmap RAMs (usable, free) of
// 64-bit words, walked one word at a time by a small sequencer; one item is in flight and
// req.ready is high only when the sequencer is idle. After reset, and on every begin item,
// both bitmaps are swept to zero at one word per cycle; no request is taken during the sweep.
// Map region of a usable kind walks each bitmap word that the region covers; allocate scans
// word by word (next-fit from the hint, then a wrap from frame 1); free reads and updates one
// word. The response sits in an output register, so the next request is taken while a
// response waits to be transferred.
module bitmap_frame_allocator #(
    parameter int TRACKED_FRAMES = 65536,
    parameter int FRAME_SHIFT    = 12
) (
    input logic clk,
    input logic rst_n,
    bfa_req_if.sink   req,
    bfa_rsp_if.source rsp
);
    import bfa_pkg::*;

    localparam int FIW = $clog2(TRACKED_FRAMES) + 1;
    localparam int MW  = (TRACKED_FRAMES + 63) / 64;
    localparam int WAW = $clog2(MW);
    localparam logic [48:0] TRACKED_BYTES = 49'(TRACKED_FRAMES) << FRAME_SHIFT;
    localparam logic [47:0] FRAC_MASK = (48'd1 << FRAME_SHIFT) - 48'd1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_MAP_PREP, S_MAP_LIM, S_MAP_RD, S_MAP_WR, S_MAP_CNT,
        S_SCAN_START, S_SCAN_RD, S_SCAN_CHK, S_SCAN_END, S_ALLOC_WR,
        S_FREE_RD, S_FREE_CHK, S_DONE
    } state_t;

    state_t           state_reg;
    logic [WAW-1:0]   w_reg;
    logic [FIW-1:0]   lo_reg, hi_reg, f_reg;
    logic [FIW-1:0]   tracked_reg, free_reg, limit_reg, hint_reg;
    logic             ready_reg, pass_reg, clr_rsp_reg;
    logic [63:0]      total_reg, usable_reg, kernel_reg, fb_reg, recl_reg;
    logic [47:0]      base_reg, len_reg;
    logic [63:0]      word_reg, onehot_reg;
    logic [3:0]       bytecnt_reg [8];
    logic [47:0]      addr_reg;
    logic             status_reg;
    logic             rsp_valid_reg;
    logic [47:0]      rsp_addr_reg;
    logic             rsp_status_reg;
    logic [FIW-1:0]   rsp_free_reg, rsp_tracked_reg;
    logic [63:0]      rsp_total_reg, rsp_usable_reg, rsp_kernel_reg, rsp_fb_reg, rsp_recl_reg;

    logic [63:0]      rd_use, rd_free;
    logic             use_we, free_we;
    logic [63:0]      use_wdata, free_wdata;

    // Span of frames [lo, hi) within the current word.
    logic [FIW-1:0]   hm1, w_ext;
    logic [5:0]       fb;
    logic [6:0]       eb;
    logic             at_last;
    logic [63:0]      span, fresh, cand, iso, free_oh;
    logic [5:0]       iso_idx;
    logic [48:0]      end_sum, end_clip;
    logic [47:0]      lo_bytes, faddr_frame;
    logic [FIW-1:0]   lo_fix, f_next;
    logic [6:0]       pop_sum;

    always_comb
    begin
        hm1     = hi_reg - FIW'(1);
        w_ext   = FIW'(w_reg);
        at_last = (w_ext == (hm1 >> 6));
        fb      = (w_ext == (lo_reg >> 6)) ? lo_reg[5:0] : 6'd0;
        eb      = at_last ? ({1'b0, hm1[5:0]} + 7'd1) : 7'd64;
        span    = ({64{1'b1}} << fb) & ~({64{1'b1}} << eb);
        fresh   = span & ~rd_use;
        cand    = rd_free & span;
        iso     = cand & (~cand + 64'd1);
        iso_idx = onehot_index(iso);
        free_oh = 64'd1 << f_reg[5:0];
        end_sum  = {1'b0, base_reg} + {1'b0, len_reg};
        end_clip = (end_sum > TRACKED_BYTES) ? TRACKED_BYTES : end_sum;
        lo_bytes = (base_reg >> FRAME_SHIFT) + {47'd0, (base_reg & FRAC_MASK) != 48'd0};
        lo_fix   = (lo_reg == '0) ? FIW'(1) : lo_reg;
        f_next   = f_reg + FIW'(1);
        faddr_frame = req.free_address >> FRAME_SHIFT;
        pop_sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            pop_sum = pop_sum + {3'd0, bytecnt_reg[i]};
        end
    end

    always_comb
    begin
        use_we     = 1'b0;
        free_we    = 1'b0;
        use_wdata  = '0;
        free_wdata = '0;
        unique case (state_reg)
            S_CLR:
            begin
                use_we  = 1'b1;
                free_we = 1'b1;
            end
            S_MAP_WR:
            begin
                use_we     = 1'b1;
                use_wdata  = rd_use | span;
                free_we    = 1'b1;
                free_wdata = rd_free | fresh;
            end
            S_ALLOC_WR:
            begin
                free_we    = 1'b1;
                free_wdata = word_reg & ~onehot_reg;
            end
            S_FREE_CHK:
            begin
                free_we    = ((rd_use & free_oh) != '0) && ((rd_free & free_oh) == '0);
                free_wdata = rd_free | free_oh;
            end
            default:
            begin
                use_we = 1'b0;
            end
        endcase
    end

    bfa_ram #(.WIDTH(WORD_BITS), .DEPTH(MW)) u_usable (
        .clk(clk), .we(use_we), .waddr(w_reg), .wdata(use_wdata),
        .raddr(w_reg), .rdata(rd_use)
    );

    bfa_ram #(.WIDTH(WORD_BITS), .DEPTH(MW)) u_free (
        .clk(clk), .we(free_we), .waddr(w_reg), .wdata(free_wdata),
        .raddr(w_reg), .rdata(rd_free)
    );

    assign req.ready             = (state_reg == S_IDLE);
    assign rsp.valid             = rsp_valid_reg;
    assign rsp.result_address    = rsp_addr_reg;
    assign rsp.status            = rsp_status_reg;
    assign rsp.free_count        = 17'(rsp_free_reg);
    assign rsp.tracked_count     = 17'(rsp_tracked_reg);
    assign rsp.total_bytes       = rsp_total_reg;
    assign rsp.usable_bytes      = rsp_usable_reg;
    assign rsp.kernel_bytes      = rsp_kernel_reg;
    assign rsp.framebuffer_bytes = rsp_fb_reg;
    assign rsp.reclaimable_bytes = rsp_recl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            w_reg         <= '0;
            tracked_reg   <= '0;
            free_reg      <= '0;
            limit_reg     <= FIW'(1);
            hint_reg      <= FIW'(1);
            ready_reg     <= 1'b0;
            pass_reg      <= 1'b0;
            clr_rsp_reg   <= 1'b0;
            total_reg     <= '0;
            usable_reg    <= '0;
            kernel_reg    <= '0;
            fb_reg        <= '0;
            recl_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    w_reg <= w_reg + WAW'(1);
                    if (w_reg == WAW'(MW - 1))
                    begin
                        w_reg     <= '0;
                        state_reg <= clr_rsp_reg ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        addr_reg   <= '0;
                        status_reg <= !ready_reg;
                        base_reg   <= req.region_base;
                        len_reg    <= req.region_length;
                        state_reg  <= S_DONE;
                        priority case (req.mode)
                            MODE_BEGIN:
                            begin
                                tracked_reg <= '0;
                                free_reg    <= '0;
                                limit_reg   <= FIW'(1);
                                hint_reg    <= FIW'(1);
                                ready_reg   <= 1'b0;
                                total_reg   <= '0;
                                usable_reg  <= '0;
                                kernel_reg  <= '0;
                                fb_reg      <= '0;
                                recl_reg    <= '0;
                                status_reg  <= 1'b0;
                                clr_rsp_reg <= 1'b1;
                                w_reg       <= '0;
                                state_reg   <= S_CLR;
                            end
                            MODE_MAP:
                            begin
                                status_reg <= 1'b0;
                                if (req.region_kind <= KIND_FRAMEBUFFER)
                                begin
                                    total_reg <= sat_add(total_reg, req.region_length);
                                end
                                if (req.region_kind == KIND_KERNEL)
                                begin
                                    kernel_reg <= sat_add(kernel_reg, req.region_length);
                                end
                                if (req.region_kind == KIND_FRAMEBUFFER)
                                begin
                                    fb_reg <= sat_add(fb_reg, req.region_length);
                                end
                                if (req.region_kind == KIND_BOOT_RECL)
                                begin
                                    recl_reg <= sat_add(recl_reg, req.region_length);
                                end
                                if (req.region_kind == KIND_USABLE)
                                begin
                                    usable_reg <= sat_add(usable_reg, req.region_length);
                                    state_reg  <= S_MAP_PREP;
                                end
                            end
                            MODE_FINISH:
                            begin
                                ready_reg  <= (free_reg != '0);
                                status_reg <= (free_reg == '0);
                            end
                            MODE_ALLOC:
                            begin
                                status_reg <= 1'b1;
                                if (ready_reg)
                                begin
                                    lo_reg    <= hint_reg;
                                    hi_reg    <= limit_reg;
                                    pass_reg  <= 1'b0;
                                    state_reg <= S_SCAN_START;
                                end
                            end
                            MODE_FREE:
                            begin
                                status_reg <= 1'b1;
                                f_reg      <= FIW'(faddr_frame);
                                w_reg      <= WAW'(faddr_frame >> 6);
                                if (ready_reg && req.free_address != '0
                                    && (req.free_address & FRAC_MASK) == '0
                                    && faddr_frame < 48'(TRACKED_FRAMES))
                                begin
                                    state_reg <= S_FREE_RD;
                                end
                            end
                            default:
                            begin
                                status_reg <= !ready_reg;
                            end
                        endcase
                    end
                end
                S_MAP_PREP:
                begin
                    hi_reg    <= FIW'(end_clip >> FRAME_SHIFT);
                    lo_reg    <= FIW'(lo_bytes);
                    state_reg <= S_MAP_LIM;
                    if (len_reg == '0 || {1'b0, base_reg} >= TRACKED_BYTES)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_MAP_LIM:
                begin
                    if (hi_reg > limit_reg)
                    begin
                        limit_reg <= hi_reg;
                    end
                    lo_reg <= lo_fix;
                    w_reg  <= WAW'(lo_fix >> 6);
                    state_reg <= (lo_fix >= hi_reg) ? S_DONE : S_MAP_RD;
                end
                S_MAP_RD:
                begin
                    state_reg <= S_MAP_WR;
                end
                S_MAP_WR:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        bytecnt_reg[i] <= pop8(fresh[i*8 +: 8]);
                    end
                    pass_reg  <= at_last;
                    state_reg <= S_MAP_CNT;
                end
                S_MAP_CNT:
                begin
                    tracked_reg <= tracked_reg + FIW'(pop_sum);
                    free_reg    <= free_reg + FIW'(pop_sum);
                    if (pass_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        w_reg     <= w_reg + WAW'(1);
                        state_reg <= S_MAP_RD;
                    end
                end
                S_SCAN_START:
                begin
                    w_reg     <= WAW'(lo_reg >> 6);
                    state_reg <= (lo_reg >= hi_reg) ? S_SCAN_END : S_SCAN_RD;
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    if (cand != '0)
                    begin
                        f_reg      <= FIW'({w_reg, iso_idx});
                        word_reg   <= rd_free;
                        onehot_reg <= iso;
                        state_reg  <= S_ALLOC_WR;
                    end
                    else if (at_last)
                    begin
                        state_reg <= S_SCAN_END;
                    end
                    else
                    begin
                        w_reg     <= w_reg + WAW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_END:
                begin
                    if (!pass_reg && hint_reg > FIW'(1))
                    begin
                        lo_reg    <= FIW'(1);
                        hi_reg    <= hint_reg;
                        pass_reg  <= 1'b1;
                        state_reg <= S_SCAN_START;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_ALLOC_WR:
                begin
                    free_reg   <= free_reg - FIW'(1);
                    hint_reg   <= (f_next >= limit_reg) ? FIW'(1) : f_next;
                    addr_reg   <= 48'(f_reg) << FRAME_SHIFT;
                    status_reg <= 1'b0;
                    state_reg  <= S_DONE;
                end
                S_FREE_RD:
                begin
                    state_reg <= S_FREE_CHK;
                end
                S_FREE_CHK:
                begin
                    if (free_we)
                    begin
                        free_reg   <= free_reg + FIW'(1);
                        status_reg <= 1'b0;
                        if (f_reg < hint_reg)
                        begin
                            hint_reg <= f_reg;
                        end
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg   <= 1'b1;
                        rsp_addr_reg    <= addr_reg;
                        rsp_status_reg  <= status_reg;
                        rsp_free_reg    <= free_reg;
                        rsp_tracked_reg <= tracked_reg;
                        rsp_total_reg   <= total_reg;
                        rsp_usable_reg  <= usable_reg;
                        rsp_kernel_reg  <= kernel_reg;
                        rsp_fb_reg      <= fb_reg;
                        rsp_recl_reg    <= recl_reg;
                        clr_rsp_reg     <= 1'b0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
